// File: rtl/pcc_pkg.sv
`timescale 1ns / 1ps

package pcc_pkg;

   // sizes fixed by the beat fields
   localparam int TASK_W        = 6;
   localparam int CNT_W         = 7;
   localparam int MAX_TASKS     = 64;
   localparam int MAX_EDGES_DEF = 256;

   // result codes
   localparam logic [1:0] STATUS_ACYCLIC  = 2'd0;
   localparam logic [1:0] STATUS_CYCLE    = 2'd1;
   localparam logic [1:0] STATUS_RANGE    = 2'd2;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

   typedef struct packed {
      logic [TASK_W-1:0] from_task;
      logic [TASK_W-1:0] to_task;
      logic              has_edge;
      logic              last;
   } pcc_req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [CNT_W-1:0] processed_count;
   } pcc_rsp_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_EVAL,
      ST_INIT,
      ST_POP,
      ST_SCAN,
      ST_DONE
   } pcc_state_type;

   typedef enum logic [1:0] {
      DEG_INC,
      DEG_DEC,
      DEG_TEST
   } pcc_deg_op_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic init_start;
      logic test_issue;
      logic pop;
      logic scan_issue;
      logic finish;
   } pcc_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic err_any;
      logic init_done;
      logic queue_empty;
      logic pipe_idle;
      logic scan_done;
      logic out_free;
   } pcc_stat_type;

endpackage

// File: rtl/pcc_ctrl.sv
`timescale 1ns / 1ps

module pcc_ctrl import pcc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_last,
   input  pcc_stat_type stat,
   output pcc_cmd_type  cmd,
   output logic         req_stall
);

   pcc_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_valid && req_last) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            state_in = stat.err_any ? ST_DONE : ST_INIT;
         end
         ST_INIT: begin
            if (stat.init_done) state_in = ST_POP;
         end
         ST_POP: begin
            if (stat.pipe_idle) state_in = stat.queue_empty ? ST_DONE : ST_SCAN;
         end
         ST_SCAN: begin
            if (stat.scan_done) state_in = ST_POP;
         end
         ST_DONE: begin
            if (stat.out_free) state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // commands
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_LOAD: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_EVAL: begin
            cmd.init_start = !stat.err_any;
         end
         ST_INIT: begin
            cmd.test_issue = !stat.init_done;
         end
         ST_POP: begin
            cmd.pop = stat.pipe_idle && !stat.queue_empty;
         end
         ST_SCAN: begin
            cmd.scan_issue = !stat.scan_done;
         end
         ST_DONE: begin
            cmd.finish = stat.out_free;
         end
         default: cmd = '0;
      endcase
   end

endmodule

// File: rtl/pcc_datapath.sv
`timescale 1ns / 1ps

module pcc_datapath import pcc_pkg::*; #(
   parameter int MAX_EDGES = MAX_EDGES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  pcc_cmd_type      cmd,
   input  pcc_req_type      req_payload,
   input  logic             csr_write,
   input  logic [CNT_W-1:0] csr_data,
   input  logic             rsp_stall,
   output pcc_stat_type     stat,
   output logic             rsp_valid,
   output pcc_rsp_type      rsp_payload
);

   localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int ET_W = $clog2(MAX_EDGES + 1);
   localparam logic [ET_W-1:0] EDGE_LIMIT = ET_W'(MAX_EDGES);
   localparam logic [CNT_W-1:0] TASK_LIMIT = CNT_W'(MAX_TASKS);

   // memories
   logic [2*TASK_W-1:0] edge_mem [MAX_EDGES];
   logic [ET_W-1:0]     deg_mem  [MAX_TASKS];
   logic [TASK_W-1:0]   q_mem    [MAX_TASKS];

   logic [CNT_W-1:0]    task_count_ff, task_count_in;
   logic [ET_W-1:0]     edge_total_ff, edge_total_in;
   logic                err_range_ff, err_range_in;
   logic                err_ovf_ff, err_ovf_in;
   logic [CNT_W-1:0]    test_ff, test_in;
   logic [ET_W-1:0]     scan_ff, scan_in;
   logic                edge_rd_vld_ff, edge_rd_vld_in;
   logic [2*TASK_W-1:0] edge_rd_q;
   logic                dg_vld_ff, dg_vld_in;
   pcc_deg_op_type      dg_op_ff;
   logic [TASK_W-1:0]   dg_addr_ff;
   logic [ET_W-1:0]     deg_rd_q;
   logic                fwd_ff, fwd_in;
   logic [ET_W-1:0]     fwd_val_ff;
   logic [MAX_TASKS-1:0] deg_vld_ff, deg_vld_in;
   logic [CNT_W-1:0]    head_ff, head_in;
   logic [CNT_W-1:0]    tail_ff, tail_in;
   logic [TASK_W-1:0]   q_rd_q;
   logic                rsp_valid_ff, rsp_valid_in;
   pcc_rsp_type         rsp_ff, rsp_in;

   logic [CNT_W-1:0]    ntasks;
   logic                in_range, store_full, edge_wr, range_hit, ovf_hit;
   logic                dg_issue;
   pcc_deg_op_type      dg_op;
   logic [TASK_W-1:0]   dg_addr;
   logic [ET_W-1:0]     dg_base, dg_new;
   logic                dg_wr, dg_zero, enq;

   // effective task count saturates
   assign ntasks = (task_count_ff > TASK_LIMIT) ? TASK_LIMIT : task_count_ff;
   assign task_count_in = csr_write ? csr_data : task_count_ff;

   // edge load decode
   assign in_range   = ({1'b0, req_payload.from_task} < ntasks)
                    && ({1'b0, req_payload.to_task} < ntasks);
   assign store_full = (edge_total_ff == EDGE_LIMIT);
   assign edge_wr    = cmd.accept && req_payload.has_edge && in_range && !store_full;
   assign range_hit  = cmd.accept && req_payload.has_edge && !in_range;
   assign ovf_hit    = cmd.accept && req_payload.has_edge && in_range && store_full;

   assign edge_total_in = cmd.finish ? '0 : (edge_wr ? edge_total_ff + 1'b1 : edge_total_ff);
   assign err_range_in  = !cmd.finish && (err_range_ff || range_hit);
   assign err_ovf_in    = !cmd.finish && (err_ovf_ff || ovf_hit);

   // init and scan counters
   assign test_in = cmd.init_start ? '0 : (cmd.test_issue ? test_ff + 1'b1 : test_ff);
   assign scan_in = cmd.pop ? '0 : (cmd.scan_issue ? scan_ff + 1'b1 : scan_ff);
   assign edge_rd_vld_in = cmd.scan_issue;

   // in-degree unit request select
   always_comb begin
      dg_issue = 1'b0;
      dg_op    = DEG_INC;
      dg_addr  = req_payload.to_task;
      if (edge_wr) begin
         dg_issue = 1'b1;
      end else if (cmd.test_issue) begin
         dg_issue = 1'b1;
         dg_op    = DEG_TEST;
         dg_addr  = test_ff[TASK_W-1:0];
      end else if (edge_rd_vld_ff && (edge_rd_q[2*TASK_W-1:TASK_W] == q_rd_q)) begin
         dg_issue = 1'b1;
         dg_op    = DEG_DEC;
         dg_addr  = edge_rd_q[TASK_W-1:0];
      end
   end
   assign dg_vld_in = dg_issue;

   // in-degree update stage with forwarding of the write on the read edge
   always_comb begin
      if (fwd_ff) begin
         dg_base = fwd_val_ff;
      end else if (deg_vld_ff[dg_addr_ff]) begin
         dg_base = deg_rd_q;
      end else begin
         dg_base = '0;
      end
      case (dg_op_ff)
         DEG_INC: dg_new = dg_base + 1'b1;
         DEG_DEC: dg_new = (dg_base != '0) ? dg_base - 1'b1 : dg_base;
         default: dg_new = dg_base;
      endcase
   end
   assign dg_wr   = dg_vld_ff && (dg_op_ff != DEG_TEST);
   assign dg_zero = dg_vld_ff
                 && (((dg_op_ff == DEG_DEC) && (dg_base == ET_W'(1)))
                  || ((dg_op_ff == DEG_TEST) && (dg_base == '0)));
   assign fwd_in  = dg_wr && dg_issue && (dg_addr_ff == dg_addr);

   always_comb begin
      deg_vld_in = deg_vld_ff;
      if (cmd.finish) begin
         deg_vld_in = '0;
      end else if (dg_wr) begin
         deg_vld_in[dg_addr_ff] = 1'b1;
      end
   end

   // ready queue pointers; head doubles as processed count
   assign enq     = dg_zero && (tail_ff < TASK_LIMIT);
   assign tail_in = cmd.finish ? '0 : (enq ? tail_ff + 1'b1 : tail_ff);
   assign head_in = cmd.finish ? '0 : (cmd.pop ? head_ff + 1'b1 : head_ff);

   // result register
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.finish) begin
         rsp_in.processed_count = '0;
         if (err_range_ff) begin
            rsp_in.status = STATUS_RANGE;
         end else if (err_ovf_ff) begin
            rsp_in.status = STATUS_OVERFLOW;
         end else begin
            rsp_in.processed_count = head_ff;
            rsp_in.status = (head_ff == ntasks) ? STATUS_ACYCLIC : STATUS_CYCLE;
         end
      end
   end
   assign rsp_valid_in = cmd.finish || (rsp_valid_ff && rsp_stall);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         task_count_ff  <= TASK_LIMIT;
         edge_total_ff  <= '0;
         err_range_ff   <= 1'b0;
         err_ovf_ff     <= 1'b0;
         test_ff        <= '0;
         scan_ff        <= '0;
         edge_rd_vld_ff <= 1'b0;
         dg_vld_ff      <= 1'b0;
         fwd_ff         <= 1'b0;
         deg_vld_ff     <= '0;
         head_ff        <= '0;
         tail_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         task_count_ff  <= task_count_in;
         edge_total_ff  <= edge_total_in;
         err_range_ff   <= err_range_in;
         err_ovf_ff     <= err_ovf_in;
         test_ff        <= test_in;
         scan_ff        <= scan_in;
         edge_rd_vld_ff <= edge_rd_vld_in;
         dg_vld_ff      <= dg_vld_in;
         fwd_ff         <= fwd_in;
         deg_vld_ff     <= deg_vld_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      dg_op_ff   <= dg_op;
      dg_addr_ff <= dg_addr;
      fwd_val_ff <= dg_new;
      rsp_ff     <= rsp_in;
   end

   // edge store
   always_ff @(posedge clock) begin
      if (edge_wr) begin
         edge_mem[edge_total_ff[EA_W-1:0]] <= {req_payload.from_task, req_payload.to_task};
      end
      if (cmd.scan_issue) begin
         edge_rd_q <= edge_mem[scan_ff[EA_W-1:0]];
      end
   end

   // in-degree store
   always_ff @(posedge clock) begin
      if (dg_wr) begin
         deg_mem[dg_addr_ff] <= dg_new;
      end
      if (dg_issue) begin
         deg_rd_q <= deg_mem[dg_addr];
      end
   end

   // ready queue store
   always_ff @(posedge clock) begin
      if (enq) begin
         q_mem[tail_ff[TASK_W-1:0]] <= dg_addr_ff;
      end
      if (cmd.pop) begin
         q_rd_q <= q_mem[head_ff[TASK_W-1:0]];
      end
   end

   // status to controller
   assign stat.err_any     = err_range_ff || err_ovf_ff;
   assign stat.init_done   = (test_ff == ntasks);
   assign stat.queue_empty = (head_ff == tail_ff);
   assign stat.pipe_idle   = !edge_rd_vld_ff && !dg_vld_ff;
   assign stat.scan_done   = (scan_ff == edge_total_ff);
   assign stat.out_free    = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// File: rtl/precedence_cycle_check.sv
`timescale 1ns / 1ps

// Precedence cycle check: edges (from_task, to_task) stream in one beat per
// cycle while req_stall is low and are stored while the in-degree of each
// target is counted. The beat marked last closes the problem; no result
// comes for other beats. With an error latched the walk is skipped and the
// result is registered directly. Otherwise a Kahn walk runs: the n tasks are
// tested, those with in-degree zero queued (n = task_count capped at 64), then
// each popped task starts a full pass over the E stored edges through the
// single read port of the edge store. No clearing pass is needed after reset
// or between problems. The output register holds a finished result while the
// next edge list loads; the user writes task_count over the csr port only
// while idle, and the block itself does not enforce this.
module precedence_cycle_check import pcc_pkg::*; #(
   parameter int MAX_EDGES = MAX_EDGES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pcc_req_type      req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pcc_rsp_type      rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CNT_W-1:0] csr_data
);

   pcc_cmd_type  cmd;
   pcc_stat_type stat;

   // register writes are always taken
   assign csr_ready = 1'b1;

   pcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_payload.last),
      .stat      (stat),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   pcc_datapath #(
      .MAX_EDGES (MAX_EDGES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .csr_write   (csr_valid && csr_ready),
      .csr_data    (csr_data),
      .rsp_stall   (rsp_stall),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: rtl/pcc_checker.sv
`timescale 1ns / 1ps

module pcc_checker import pcc_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input pcc_req_type req_payload,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input pcc_rsp_type rsp_payload
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result beat changed while stalled");

   // error results carry no processed count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_payload.status == STATUS_RANGE)
                 || (rsp_payload.status == STATUS_OVERFLOW))
      |-> rsp_payload.processed_count == '0)
      else $error("error result with nonzero count");

   // never more tasks processed than exist
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.processed_count <= CNT_W'(MAX_TASKS))
      else $error("processed count too large");

   // the closing beat ends the load, so input stalls next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_payload.last |=> req_stall)
      else $error("input not stalled after last beat");

endmodule

bind precedence_cycle_check pcc_checker u_pcc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
